@@ rtl/hcvd_pkg.sv @@
// ----------------------------------------------------------------------------
// hcvd_pkg
// shared types and constants of the hsv colour vote detector
// ----------------------------------------------------------------------------
package hcvd_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SAT_MIN    = 3'd0,
      CSR_VAL_MIN    = 3'd1,
      CSR_VOTE_LIMIT = 3'd2,
      CSR_ROW_START  = 3'd3,
      CSR_ROW_END    = 3'd4,
      CSR_COL_START  = 3'd5,
      CSR_COL_END    = 3'd6
   } csr_index_type;

   // register widths
   localparam int THRESH_W = 10;
   localparam int LIMIT_W  = 4;
   localparam int WIN_W    = 12;

   // register reset values
   localparam logic [THRESH_W-1:0] SAT_MIN_RST    = 10'd200;
   localparam logic [THRESH_W-1:0] VAL_MIN_RST    = 10'd500;
   localparam logic [LIMIT_W-1:0]  VOTE_LIMIT_RST = 4'd3;
   localparam logic [WIN_W-1:0]    ROW_START_RST  = 12'd96;
   localparam logic [WIN_W-1:0]    ROW_END_RST    = 12'd480;
   localparam logic [WIN_W-1:0]    COL_START_RST  = 12'd213;
   localparam logic [WIN_W-1:0]    COL_END_RST    = 12'd426;

   // pixel and result widths
   localparam int CHAN_W      = 8;
   localparam int VOTE_W      = 5;
   localparam int ROW_SUM_W   = 16;
   localparam int MEAN_W      = 16;
   localparam int MEAN_FRAC_W = 4;
   localparam int DIVIDEND_W  = ROW_SUM_W + MEAN_FRAC_W;
   localparam int DIV_CNT_W   = 5;
   localparam int NUM_COLOURS = 4;
   localparam int COLOUR_W    = 2;

   // products of the saturation and value tests
   localparam int PROD_TEST_W = 18;

   // front to back queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef enum logic [COLOUR_W-1:0] {
      COLOUR_PINK   = 2'd0,
      COLOUR_BLUE   = 2'd1,
      COLOUR_GREEN  = 2'd2,
      COLOUR_ORANGE = 2'd3
   } colour_type;

   // which channel holds the maximum
   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } sector_type;

   typedef enum logic {
      BACK_IDLE   = 1'b0,
      BACK_DIVIDE = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [THRESH_W-1:0] sat_min;
      logic [THRESH_W-1:0] val_min;
      logic [LIMIT_W-1:0]  vote_limit;
      logic [WIN_W-1:0]    row_start;
      logic [WIN_W-1:0]    row_end;
      logic [WIN_W-1:0]    col_start;
      logic [WIN_W-1:0]    col_end;
   } cfg_type;

   // classified pixel handed from front to back
   typedef struct packed {
      logic                 last;
      logic                 sample;
      logic                 vote;
      colour_type           colour;
      logic [ROW_SUM_W-1:0] row;
      logic [LIMIT_W-1:0]   vote_limit;
   } item_type;

endpackage

@@ rtl/hsv_colour_vote_detector.sv @@
// result path: a miss item passes the two classifier stages, the queue and the result
//   register; a detected item also waits for the 20-step mean-row divider
// throughput: one pixel per cycle, set by the two-stage classifier; the vote logic halts
//   for the mean-row division at most once per frame and while a result is not taken,
//   and the input stalls only when a sampled or frame-end pixel meets a full 4-entry queue
// reset: synchronous, clears all votes, queue and the result; registers take defaults
// ----------------------------------------------------------------------------
// hsv_colour_vote_detector
// samples a pixel grid in a window, votes hue bands, reports the winning colour
// ----------------------------------------------------------------------------
module hsv_colour_vote_detector #(
   parameter int GRID_STEP  = 10,
   parameter int COORD_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   // pixel input queue side
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [hcvd_pkg::CHAN_W-1:0]      req_red,
   input  logic [hcvd_pkg::CHAN_W-1:0]      req_green,
   input  logic [hcvd_pkg::CHAN_W-1:0]      req_blue,
   input  logic [COORD_BITS-1:0]           req_pixel_row,
   input  logic [COORD_BITS-1:0]           req_pixel_col,
   input  logic                            req_frame_last,
   // result queue side
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic                            rsp_detected,
   output logic [hcvd_pkg::COLOUR_W-1:0]    rsp_colour,
   output logic [hcvd_pkg::MEAN_W-1:0]      rsp_mean_row_x16,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hcvd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hcvd_pkg::CSR_DATA_W-1:0]  csr_data
);
   import hcvd_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     front_ready;
   logic     front_valid;
   item_type front_item;
   logic     queue_full;
   logic     queue_not_empty;
   item_type queue_item;
   logic     queue_pop;
   logic     rsp_valid;

   // register file, writes always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SAT_MIN:    cfg_in.sat_min    = csr_data[THRESH_W-1:0];
            CSR_VAL_MIN:    cfg_in.val_min    = csr_data[THRESH_W-1:0];
            CSR_VOTE_LIMIT: cfg_in.vote_limit = csr_data[LIMIT_W-1:0];
            CSR_ROW_START:  cfg_in.row_start  = csr_data[WIN_W-1:0];
            CSR_ROW_END:    cfg_in.row_end    = csr_data[WIN_W-1:0];
            CSR_COL_START:  cfg_in.col_start  = csr_data[WIN_W-1:0];
            CSR_COL_END:    cfg_in.col_end    = csr_data[WIN_W-1:0];
            default:        cfg_in = cfg_ff;   // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sat_min    <= SAT_MIN_RST;
         cfg_ff.val_min    <= VAL_MIN_RST;
         cfg_ff.vote_limit <= VOTE_LIMIT_RST;
         cfg_ff.row_start  <= ROW_START_RST;
         cfg_ff.row_end    <= ROW_END_RST;
         cfg_ff.col_start  <= COL_START_RST;
         cfg_ff.col_end    <= COL_END_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: grid test and colour classification, off-grid pixels dropped
   // unless they close the frame; the vote limit travels with each item
   hcvd_front #(
      .GRID_STEP  (GRID_STEP),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_push    (req_push),
      .in_ready   (front_ready),
      .red        (req_red),
      .green      (req_green),
      .blue       (req_blue),
      .pixel_row  (req_pixel_row),
      .pixel_col  (req_pixel_col),
      .frame_last (req_frame_last),
      .out_valid  (front_valid),
      .out_item   (front_item),
      .queue_full (queue_full)
   );

   assign req_full = !front_ready;

   // decouples classification from the vote logic while it divides
   hcvd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_item  (queue_item),
      .not_empty (queue_not_empty)
   );

   // back: vote counts, first-detection and miss results
   hcvd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (queue_not_empty),
      .item             (queue_item),
      .item_pop         (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_pop          (rsp_pop),
      .rsp_detected     (rsp_detected),
      .rsp_colour       (rsp_colour),
      .rsp_mean_row_x16 (rsp_mean_row_x16)
   );

   assign rsp_empty = !rsp_valid;

endmodule

@@ rtl/hcvd_front.sv @@
// ----------------------------------------------------------------------------
// hcvd_front
// two-stage classifier: grid test, hsv thresholds and hue bands per pixel
// ----------------------------------------------------------------------------
module hcvd_front #(
   parameter int GRID_STEP  = 10,
   parameter int COORD_BITS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  hcvd_pkg::cfg_type          cfg,
   input  logic                       in_push,
   output logic                       in_ready,
   input  logic [hcvd_pkg::CHAN_W-1:0] red,
   input  logic [hcvd_pkg::CHAN_W-1:0] green,
   input  logic [hcvd_pkg::CHAN_W-1:0] blue,
   input  logic [COORD_BITS-1:0]      pixel_row,
   input  logic [COORD_BITS-1:0]      pixel_col,
   input  logic                       frame_last,
   output logic                       out_valid,
   output hcvd_pkg::item_type         out_item,
   input  logic                       queue_full
);
   import hcvd_pkg::*;

   localparam int CMP_W        = (COORD_BITS > WIN_W) ? COORD_BITS : WIN_W;
   localparam int RECIP_SHIFT  = CMP_W;
   localparam int RECIP_W      = CMP_W + 1;
   localparam int PROD_W       = CMP_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SHIFT) / GRID_STEP);
   localparam int HUE_W        = 11;
   localparam int BAND_W       = 14;

   // hue bands in units of 60 degrees times d, scaled to integers
   localparam logic [BAND_W-1:0] K_THREE    = 14'd3;
   localparam logic [BAND_W-1:0] K_FOUR     = 14'd4;
   localparam logic [BAND_W-1:0] K_FIVE     = 14'd5;
   localparam logic [BAND_W-1:0] K_SIX      = 14'd6;
   localparam logic [BAND_W-1:0] K_EIGHT    = 14'd8;
   localparam logic [BAND_W-1:0] K_THIRTEEN = 14'd13;
   localparam logic [BAND_W-1:0] K_NINETEEN = 14'd19;
   localparam logic [PROD_TEST_W-1:0] K_THOUSAND = 18'd1000;
   localparam logic [PROD_TEST_W-1:0] K_FULL     = 18'd255;

   logic adv;
   logic accept;

   // stage 1 registers
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_last_ff;
   logic                   s1_win_ff;
   logic [CMP_W-1:0]       s1_xr_ff, s1_xc_ff;
   logic [ROW_SUM_W-1:0]   s1_row_ff;
   logic [CHAN_W-1:0]      s1_mx_ff, s1_d_ff;
   logic [CHAN_W:0]        s1_n_ff;
   sector_type             s1_sector_ff;
   logic [THRESH_W-1:0]    s1_sat_min_ff, s1_val_min_ff;
   logic [LIMIT_W-1:0]     s1_limit_ff;

   // stage 2 registers
   logic                   s2_valid_ff, s2_valid_in;
   logic                   s2_last_ff;
   logic                   s2_win_ff;
   logic [CMP_W-1:0]       s2_xr_ff, s2_xc_ff, s2_qr_ff, s2_qc_ff;
   logic [ROW_SUM_W-1:0]   s2_row_ff;
   logic [PROD_TEST_W-1:0] s2_sat_l_ff, s2_sat_r_ff, s2_val_l_ff, s2_val_r_ff;
   logic [HUE_W-1:0]       s2_hue_ff;
   logic [CHAN_W-1:0]      s2_d_ff;
   logic [LIMIT_W-1:0]     s2_limit_ff;

   // stage 1 logic
   logic [CMP_W-1:0]  row_ext, col_ext;
   logic              row_in, col_in;
   logic [CHAN_W-1:0] mx, mn;
   sector_type        sector;
   logic [CHAN_W:0]   hue_n;

   always_comb begin
      row_ext = CMP_W'(pixel_row);
      col_ext = CMP_W'(pixel_col);
      row_in  = (row_ext >= CMP_W'(cfg.row_start)) && (row_ext < CMP_W'(cfg.row_end));
      col_in  = (col_ext >= CMP_W'(cfg.col_start)) && (col_ext < CMP_W'(cfg.col_end));
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      if (red == mx) begin
         sector = SECTOR_RED;
         hue_n  = {1'b0, green} - {1'b0, blue};
      end else if (green == mx) begin
         sector = SECTOR_GREEN;
         hue_n  = {1'b0, blue} - {1'b0, red};
      end else begin
         sector = SECTOR_BLUE;
         hue_n  = {1'b0, red} - {1'b0, green};
      end
   end

   // stage 2 logic: reciprocal quotients, test products, hue times d over 60
   logic [PROD_W-1:0] prod_r, prod_c;
   logic [HUE_W-1:0]  kd, d6;
   logic [HUE_W:0]    hue_raw, hue_wrap;
   logic [HUE_W-1:0]  hue;

   always_comb begin
      prod_r = PROD_W'(s1_xr_ff) * PROD_W'(RECIP);
      prod_c = PROD_W'(s1_xc_ff) * PROD_W'(RECIP);
      d6     = {1'b0, s1_d_ff, 2'b00} + {2'b00, s1_d_ff, 1'b0};
      unique case (s1_sector_ff)
         SECTOR_GREEN: kd = {2'b00, s1_d_ff, 1'b0};
         SECTOR_BLUE:  kd = {1'b0, s1_d_ff, 2'b00};
         default:      kd = '0;
      endcase
      hue_raw  = {{(HUE_W-CHAN_W){s1_n_ff[CHAN_W]}}, s1_n_ff} + {1'b0, kd};
      hue_wrap = hue_raw + {1'b0, d6};
      hue      = hue_raw[HUE_W] ? hue_wrap[HUE_W-1:0] : hue_raw[HUE_W-1:0];
   end

   // final classification on stage 2 registers
   logic [CMP_W-1:0]  rem_r, rem_c;
   logic              grid_ok, sat_ok, val_ok, band_hit, keep;
   colour_type        band;
   logic [BAND_W-1:0] h1, d1;

   always_comb begin
      rem_r   = s2_xr_ff - CMP_W'(s2_qr_ff * CMP_W'(GRID_STEP));
      rem_c   = s2_xc_ff - CMP_W'(s2_qc_ff * CMP_W'(GRID_STEP));
      // remainder estimate is below twice the step
      grid_ok = s2_win_ff &&
                ((rem_r == '0) || (rem_r == CMP_W'(GRID_STEP))) &&
                ((rem_c == '0) || (rem_c == CMP_W'(GRID_STEP)));
      sat_ok  = s2_sat_l_ff > s2_sat_r_ff;
      val_ok  = s2_val_l_ff > s2_val_r_ff;
      h1      = BAND_W'(s2_hue_ff);
      d1      = BAND_W'(s2_d_ff);
      band_hit = 1'b1;
      priority if ((K_FIVE * d1 < h1) && (h1 < K_SIX * d1)) begin
         band = COLOUR_PINK;
      end else if ((h1 != '0) && (h1 < d1)) begin
         band = COLOUR_ORANGE;
      end else if ((K_NINETEEN * d1 < K_SIX * h1) && (K_THREE * h1 < K_THIRTEEN * d1)) begin
         band = COLOUR_BLUE;
      end else if ((K_FOUR * d1 < K_THREE * h1) && (K_THREE * h1 < K_EIGHT * d1)) begin
         band = COLOUR_GREEN;
      end else begin
         band     = COLOUR_PINK;
         band_hit = 1'b0;
      end
      keep = grid_ok || s2_last_ff;

      out_item.last       = s2_last_ff;
      out_item.sample     = grid_ok;
      out_item.vote       = sat_ok && val_ok && band_hit;
      out_item.colour     = band;
      out_item.row        = s2_row_ff;
      out_item.vote_limit = s2_limit_ff;
      out_valid = s2_valid_ff && keep;
   end

   assign adv         = !(out_valid && queue_full);
   assign in_ready    = adv;
   assign accept      = in_push && adv;
   assign s1_valid_in = adv ? accept : s1_valid_ff;
   assign s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_last_ff    <= frame_last;
         s1_win_ff     <= row_in && col_in;
         s1_xr_ff      <= row_ext - CMP_W'(cfg.row_start);
         s1_xc_ff      <= col_ext - CMP_W'(cfg.col_start);
         s1_row_ff     <= ROW_SUM_W'(pixel_row);
         s1_mx_ff      <= mx;
         s1_d_ff       <= mx - mn;
         s1_n_ff       <= hue_n;
         s1_sector_ff  <= sector;
         s1_sat_min_ff <= cfg.sat_min;
         s1_val_min_ff <= cfg.val_min;
         s1_limit_ff   <= cfg.vote_limit;

         s2_last_ff  <= s1_last_ff;
         s2_win_ff   <= s1_win_ff;
         s2_xr_ff    <= s1_xr_ff;
         s2_xc_ff    <= s1_xc_ff;
         s2_qr_ff    <= CMP_W'(prod_r >> RECIP_SHIFT);
         s2_qc_ff    <= CMP_W'(prod_c >> RECIP_SHIFT);
         s2_row_ff   <= s1_row_ff;
         s2_sat_l_ff <= PROD_TEST_W'(s1_d_ff) * K_THOUSAND;
         s2_sat_r_ff <= PROD_TEST_W'(s1_sat_min_ff) * PROD_TEST_W'(s1_mx_ff);
         s2_val_l_ff <= PROD_TEST_W'(s1_mx_ff) * K_THOUSAND;
         s2_val_r_ff <= PROD_TEST_W'(s1_val_min_ff) * K_FULL;
         s2_hue_ff   <= hue;
         s2_d_ff     <= s1_d_ff;
         s2_limit_ff <= s1_limit_ff;
      end
   end

endmodule

@@ rtl/hcvd_queue.sv @@
// ----------------------------------------------------------------------------
// hcvd_queue
// small register queue between classifier and vote logic
// ----------------------------------------------------------------------------
module hcvd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hcvd_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output hcvd_pkg::item_type pop_item,
   output logic               not_empty
);
   import hcvd_pkg::*;

   item_type                slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign full      = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/hcvd_divider.sv @@
// ----------------------------------------------------------------------------
// hcvd_divider
// restoring divider, one quotient bit per cycle, for the mean row
// ----------------------------------------------------------------------------
module hcvd_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [hcvd_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [hcvd_pkg::VOTE_W-1:0]     divisor,
   output logic                           done,
   output logic [hcvd_pkg::MEAN_W-1:0]     quotient
);
   import hcvd_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [VOTE_W-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [VOTE_W-1:0]     div_ff, div_in;
   logic [VOTE_W:0]       shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = VOTE_W'(shifted - {1'b0, div_ff});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[VOTE_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[MEAN_W-1:0];

endmodule

@@ rtl/hcvd_back.sv @@
// ----------------------------------------------------------------------------
// hcvd_back
// vote counting, detection, frame bookkeeping and the result register
// ----------------------------------------------------------------------------
module hcvd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_valid,
   input  hcvd_pkg::item_type          item,
   output logic                        item_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_pop,
   output logic                        rsp_detected,
   output logic [hcvd_pkg::COLOUR_W-1:0] rsp_colour,
   output logic [hcvd_pkg::MEAN_W-1:0]   rsp_mean_row_x16
);
   import hcvd_pkg::*;

   back_state_type       state_ff, state_in;
   logic [VOTE_W-1:0]    votes_ff [NUM_COLOURS];
   logic [VOTE_W-1:0]    votes_in [NUM_COLOURS];
   logic [VOTE_W-1:0]    total_ff, total_in;
   logic [ROW_SUM_W-1:0] sum_ff, sum_in;
   logic                 done_ff, done_in;
   colour_type           win_ff, win_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_det_ff, rsp_det_in;
   logic [COLOUR_W-1:0]  rsp_colour_ff, rsp_colour_in;
   logic [MEAN_W-1:0]    rsp_mean_ff, rsp_mean_in;

   logic [VOTE_W-1:0]    votes_new [NUM_COLOURS];
   logic [VOTE_W-1:0]    total_new;
   logic [ROW_SUM_W-1:0] sum_new;
   logic                 out_free, take, active, add_vote, det;
   colour_type           best;
   logic                 div_start, div_done;
   logic [MEAN_W-1:0]    div_quo;

   hcvd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_new, MEAN_FRAC_W'(0)}),
      .divisor  (total_new),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      out_free = !rsp_valid_ff || rsp_pop;
      take     = (state_ff == BACK_IDLE) && item_valid && out_free;
      active   = item.sample && !done_ff;
      add_vote = active && item.vote;
      for (int i = 0; i < NUM_COLOURS; i++) begin
         votes_new[i] = votes_ff[i] +
                        VOTE_W'(add_vote && (item.colour == colour_type'(COLOUR_W'(i))));
      end
      total_new = total_ff + VOTE_W'(add_vote);
      sum_new   = add_vote ? sum_ff + item.row : sum_ff;
      det       = active && (total_new > VOTE_W'(item.vote_limit)) && (total_new != '0);
      // lowest index wins a tie
      best = COLOUR_PINK;
      for (int i = 1; i < NUM_COLOURS; i++) begin
         if (votes_new[i] > votes_new[best]) best = colour_type'(COLOUR_W'(i));
      end
   end

   always_comb begin
      state_in  = state_ff;
      votes_in  = votes_ff;
      total_in  = total_ff;
      sum_in    = sum_ff;
      done_in   = done_ff;
      win_in    = win_ff;
      div_start = 1'b0;
      item_pop  = 1'b0;

      rsp_valid_in  = rsp_pop ? 1'b0 : rsp_valid_ff;
      rsp_det_in    = rsp_det_ff;
      rsp_colour_in = rsp_colour_ff;
      rsp_mean_in   = rsp_mean_ff;

      unique case (state_ff)
         BACK_IDLE: begin
            if (take) begin
               item_pop = 1'b1;
               votes_in = votes_new;
               total_in = total_new;
               sum_in   = sum_new;
               if (det) begin
                  done_in   = 1'b1;
                  win_in    = best;
                  div_start = 1'b1;
                  state_in  = BACK_DIVIDE;
               end
               if (item.last) begin
                  for (int i = 0; i < NUM_COLOURS; i++) votes_in[i] = '0;
                  total_in = '0;
                  sum_in   = '0;
                  done_in  = 1'b0;
                  if (!(done_ff || det)) begin
                     // miss result
                     rsp_valid_in  = 1'b1;
                     rsp_det_in    = 1'b0;
                     rsp_colour_in = COLOUR_PINK;
                     rsp_mean_in   = '0;
                  end
               end
            end
         end
         BACK_DIVIDE: begin
            if (div_done) begin
               rsp_valid_in  = 1'b1;
               rsp_det_in    = 1'b1;
               rsp_colour_in = win_ff;
               rsp_mean_in   = div_quo;
               state_in      = BACK_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         for (int i = 0; i < NUM_COLOURS; i++) votes_ff[i] <= '0;
         total_ff     <= '0;
         sum_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         votes_ff     <= votes_in;
         total_ff     <= total_in;
         sum_ff       <= sum_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff        <= win_in;
      rsp_det_ff    <= rsp_det_in;
      rsp_colour_ff <= rsp_colour_in;
      rsp_mean_ff   <= rsp_mean_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_detected     = rsp_det_ff;
   assign rsp_colour       = rsp_colour_ff;
   assign rsp_mean_row_x16 = rsp_mean_ff;

endmodule

@@ rtl/hcvd_checker.sv @@
// ----------------------------------------------------------------------------
// hcvd_checker
// port-level checks of the hsv colour vote detector
// ----------------------------------------------------------------------------
module hcvd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_full,
   input logic                            rsp_empty,
   input logic                            rsp_pop,
   input logic                            rsp_detected,
   input logic [hcvd_pkg::COLOUR_W-1:0]    rsp_colour,
   input logic [hcvd_pkg::MEAN_W-1:0]      rsp_mean_row_x16
);
   import hcvd_pkg::*;

   // reset leaves no result and an open input
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("result or full flag left after reset");

   // a miss carries zero colour and zero mean
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_detected) |-> (rsp_colour == '0) && (rsp_mean_row_x16 == '0))
      else $error("miss item with nonzero fields");

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty && $stable(rsp_detected) &&
      $stable(rsp_colour) && $stable(rsp_mean_row_x16))
      else $error("waiting result changed");

   // input open on the first cycle out of reset
   a_no_push_while_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_full)
      else $error("input full right after reset");

endmodule

bind hsv_colour_vote_detector hcvd_checker u_hcvd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_detected     (rsp_detected),
   .rsp_colour       (rsp_colour),
   .rsp_mean_row_x16 (rsp_mean_row_x16)
);

@@ tb/sv/tb_hsv_colour_vote_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hsv_colour_vote_detector
// self-checking bench: pixel frames go in through the request queue, a local
// copy of the vote logic predicts every detected or miss item, and each popped
// result is compared field by field while both sides stall at random
// ----------------------------------------------------------------------------
module tb_hsv_colour_vote_detector;
   import hcvd_pkg::*;

   localparam int GRID_STEP        = 10;
   localparam int COORD_BITS       = 12;
   // settle time after the last predicted item, to let the pipe empty
   localparam int SETTLE_CYCLES    = 40;
   localparam int LONG_HOLD_CYCLES = 400;
   // longest honest quiet stretch: the long hold plus a divide plus a long gap
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int NO_VOTE          = -1;

   typedef struct {
      logic [CHAN_W-1:0]     red;
      logic [CHAN_W-1:0]     green;
      logic [CHAN_W-1:0]     blue;
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
      logic                  last;
   } pixel_type;

   typedef struct {
      logic              detected;
      colour_type        colour;
      logic [MEAN_W-1:0] mean_row_x16;
   } verdict_type;

   // clock, reset and block inputs, all known from time zero
   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_push       = 1'b0;
   logic                   req_full;
   logic [CHAN_W-1:0]      req_red        = '0;
   logic [CHAN_W-1:0]      req_green      = '0;
   logic [CHAN_W-1:0]      req_blue       = '0;
   logic [COORD_BITS-1:0]  req_pixel_row  = '0;
   logic [COORD_BITS-1:0]  req_pixel_col  = '0;
   logic                   req_frame_last = 1'b0;
   logic                   rsp_empty;
   logic                   rsp_pop        = 1'b0;
   logic                   rsp_detected;
   logic [COLOUR_W-1:0]    rsp_colour;
   logic [MEAN_W-1:0]      rsp_mean_row_x16;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_data       = '0;

   // local copy of the registers and the per-frame tallies
   cfg_type              model_cfg;
   logic [VOTE_W-1:0]    tally_votes [NUM_COLOURS];
   logic [VOTE_W-1:0]    tally_total;
   logic [ROW_SUM_W-1:0] tally_row_sum;
   logic                 tally_done;

   pixel_type   pixel_backlog[$];
   pixel_type   pixel_on_bus;
   verdict_type pending_verdicts[$];

   int  pixels_offered   = 0;
   int  pixels_taken     = 0;
   int  verdicts_taken   = 0;
   int  verdicts_noticed = 0;
   int  mismatch_count   = 0;
   int  quiet_cycles     = 0;
   int  send_gap_left    = 0;
   int  pop_gap_left     = 0;
   int  hold_left        = 0;
   int  hold_requests    = 0;
   int  holds_started    = 0;
   bit  sender_idles     = 1'b1;
   bit  receiver_idles   = 1'b1;

   hsv_colour_vote_detector #(
      .GRID_STEP  (GRID_STEP),
      .COORD_BITS (COORD_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_pixel_row    (req_pixel_row),
      .req_pixel_col    (req_pixel_col),
      .req_frame_last   (req_frame_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_detected     (rsp_detected),
      .rsp_colour       (rsp_colour),
      .rsp_mean_row_x16 (rsp_mean_row_x16),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // vote prediction
   // ------------------------------------------------------------------------

   // sampled only on the step lattice anchored at lo, upper bound exclusive
   function automatic bit on_lattice(input logic [WIN_W-1:0] pos, lo, hi);
      if (pos < lo || pos >= hi) return 1'b0;
      return ((pos - lo) % GRID_STEP) == 0;
   endfunction

   // colour a pixel votes for, or NO_VOTE; hue compared as hue times delta
   function automatic int hue_band(input logic [CHAN_W-1:0] r8, g8, b8);
      int r, g, b, mx, mn, d, hd;
      r  = r8;
      g  = g8;
      b  = b8;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      // black and grey never pass saturation
      if (mx == 0 || d == 0) return NO_VOTE;
      if (d * 1000 <= int'(model_cfg.sat_min) * mx) return NO_VOTE;
      if (mx * 1000 <= int'(model_cfg.val_min) * 255) return NO_VOTE;
      // red wins ties for the maximum, then green
      if (r == mx)      hd = 60 * (g - b);
      else if (g == mx) hd = 60 * (2 * d + b - r);
      else              hd = 60 * (4 * d + r - g);
      if (hd < 0) hd += 360 * d;
      // open bands, edges vote for nothing
      if (hd > 300 * d && hd < 360 * d) return int'(COLOUR_PINK);
      if (hd > 0 && hd < 60 * d)        return int'(COLOUR_ORANGE);
      if (hd > 190 * d && hd < 260 * d) return int'(COLOUR_BLUE);
      if (hd > 80 * d && hd < 160 * d)  return int'(COLOUR_GREEN);
      return NO_VOTE;
   endfunction

   task automatic clear_tallies();
      for (int i = 0; i < NUM_COLOURS; i++) tally_votes[i] = '0;
      tally_total   = '0;
      tally_row_sum = '0;
      tally_done    = 1'b0;
   endtask

   // advance the frame tallies by one taken pixel, queue any item it causes
   task automatic tally_pixel(input pixel_type px);
      int                        band;
      int                        best;
      verdict_type               v;
      logic [DIVIDEND_W-1:0]     scaled;
      if (!tally_done && on_lattice(px.row, model_cfg.row_start, model_cfg.row_end) &&
          on_lattice(px.col, model_cfg.col_start, model_cfg.col_end)) begin
         band = hue_band(px.red, px.green, px.blue);
         if (band != NO_VOTE) begin
            tally_votes[band] = tally_votes[band] + 1'b1;
            tally_total       = tally_total + 1'b1;
            tally_row_sum     = tally_row_sum + ROW_SUM_W'(px.row);
         end
         // checked on every sampled pixel, voting or not
         if (tally_total > model_cfg.vote_limit && tally_total != '0) begin
            best = 0;
            // strict compare keeps the lowest index on a tie
            for (int i = 1; i < NUM_COLOURS; i++)
               if (tally_votes[i] > tally_votes[best]) best = i;
            scaled         = {tally_row_sum, {MEAN_FRAC_W{1'b0}}};
            v.detected     = 1'b1;
            v.colour       = colour_type'(best[COLOUR_W-1:0]);
            v.mean_row_x16 = MEAN_W'(scaled / tally_total);
            pending_verdicts.insert(pending_verdicts.size(), v);
            tally_done = 1'b1;
         end
      end
      if (px.last) begin
         // miss only when nothing was detected in this frame
         if (!tally_done) begin
            v.detected     = 1'b0;
            v.colour       = COLOUR_PINK;
            v.mean_row_x16 = '0;
            pending_verdicts.insert(pending_verdicts.size(), v);
         end
         clear_tallies();
      end
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   // mostly no gap, some short, a few long
   function automatic int draw_gap(input bit enabled);
      int roll;
      if (!enabled) return 0;
      roll = $urandom_range(99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [COORD_BITS-1:0] grid_pos(input logic [WIN_W-1:0] lo, hi);
      if (hi > lo) return COORD_BITS'(lo + GRID_STEP * $urandom_range((hi - lo - 1) / GRID_STEP));
      return COORD_BITS'($urandom);
   endfunction

   // saturated bright pixel that lands in some band under the current thresholds
   task automatic pick_colourful(output logic [CHAN_W-1:0] r, g, b);
      int mx, mn, mid, tries;
      tries = 0;
      do begin
         mx  = $urandom_range(255, 120);
         mn  = $urandom_range(mx * 3 / 5);
         mid = $urandom_range(mx, mn);
         case ($urandom_range(5))
            0:       begin r = 8'(mx);  g = 8'(mid); b = 8'(mn);  end
            1:       begin r = 8'(mx);  g = 8'(mn);  b = 8'(mid); end
            2:       begin r = 8'(mid); g = 8'(mx);  b = 8'(mn);  end
            3:       begin r = 8'(mn);  g = 8'(mx);  b = 8'(mid); end
            4:       begin r = 8'(mid); g = 8'(mn);  b = 8'(mx);  end
            default: begin r = 8'(mn);  g = 8'(mid); b = 8'(mx);  end
         endcase
         tries++;
      end while (hue_band(r, g, b) == NO_VOTE && tries < 30);
   endtask

   task automatic queue_pixel(input int r, g, b, row, col, input bit last);
      pixel_type px;
      px.red   = CHAN_W'(r);
      px.green = CHAN_W'(g);
      px.blue  = CHAN_W'(b);
      px.row   = COORD_BITS'(row);
      px.col   = COORD_BITS'(col);
      px.last  = last;
      pixel_backlog.insert(pixel_backlog.size(), px);
   endtask

   // frames of random length; most pixels on the lattice, the rest anywhere
   task automatic queue_frames(input int n_items, min_len, max_len, grid_pct);
      int                left, len;
      pixel_type         px;
      logic [CHAN_W-1:0] r, g, b;
      left = n_items;
      while (left > 0) begin
         len = $urandom_range(max_len, min_len);
         if (len > left) len = left;
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(99) < grid_pct) begin
               px.row = grid_pos(model_cfg.row_start, model_cfg.row_end);
               px.col = grid_pos(model_cfg.col_start, model_cfg.col_end);
               if ($urandom_range(99) < 80) begin
                  pick_colourful(r, g, b);
               end else begin
                  r = CHAN_W'($urandom);
                  g = CHAN_W'($urandom);
                  b = CHAN_W'($urandom);
               end
            end else begin
               px.row = COORD_BITS'($urandom);
               px.col = COORD_BITS'($urandom);
               r      = CHAN_W'($urandom);
               g      = CHAN_W'($urandom);
               b      = CHAN_W'($urandom);
            end
            px.red   = r;
            px.green = g;
            px.blue  = b;
            px.last  = (k == len - 1);
            pixel_backlog.insert(pixel_backlog.size(), px);
         end
         left -= len;
      end
   endtask

   // one register write, mirrored into the local copy when it is taken
   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SAT_MIN:    model_cfg.sat_min    = data[THRESH_W-1:0];
         CSR_VAL_MIN:    model_cfg.val_min    = data[THRESH_W-1:0];
         CSR_VOTE_LIMIT: model_cfg.vote_limit = data[LIMIT_W-1:0];
         CSR_ROW_START:  model_cfg.row_start  = data[WIN_W-1:0];
         CSR_ROW_END:    model_cfg.row_end    = data[WIN_W-1:0];
         CSR_COL_START:  model_cfg.col_start  = data[WIN_W-1:0];
         CSR_COL_END:    model_cfg.col_end    = data[WIN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] sat, val, lim, rs, re, cs, ce);
      csr_write(CSR_SAT_MIN, sat);
      csr_write(CSR_VAL_MIN, val);
      csr_write(CSR_VOTE_LIMIT, lim);
      csr_write(CSR_ROW_START, rs);
      csr_write(CSR_ROW_END, re);
      csr_write(CSR_COL_START, cs);
      csr_write(CSR_COL_END, ce);
   endtask

   // sender pauses until every predicted item is back, then lets the pipe empty
   task automatic wait_drained();
      while (pixel_backlog.size() != 0 || pixels_taken != pixels_offered ||
             pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int want, got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // pixel side
   // ------------------------------------------------------------------------

   // drive on the falling edge, one new item only after the last one was taken
   always @(negedge clock) begin : pixel_drive
      if (reset) begin
         req_push <= 1'b0;
      end else if (req_push && pixels_taken != pixels_offered) begin
         // item still waiting for room, hold it
      end else if (send_gap_left > 0) begin
         req_push <= 1'b0;
         send_gap_left--;
      end else if (pixel_backlog.size() != 0) begin
         pixel_on_bus    = pixel_backlog.pop_front();
         req_red        <= pixel_on_bus.red;
         req_green      <= pixel_on_bus.green;
         req_blue       <= pixel_on_bus.blue;
         req_pixel_row  <= pixel_on_bus.row;
         req_pixel_col  <= pixel_on_bus.col;
         req_frame_last <= pixel_on_bus.last;
         req_push       <= 1'b1;
         pixels_offered++;
         send_gap_left = draw_gap(sender_idles);
      end else begin
         req_push <= 1'b0;
      end
   end

   // taken pixels feed the prediction
   always @(posedge clock) begin : pixel_take
      if (!reset && req_push && !req_full) begin
         tally_pixel(pixel_on_bus);
         pixels_taken++;
      end
   end

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------

   // pop with random gaps after each item; a requested long hold wins
   always @(negedge clock) begin : verdict_pop
      int gap;
      if (hold_requests != holds_started) begin
         holds_started = hold_requests;
         hold_left     = LONG_HOLD_CYCLES;
      end
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (pop_gap_left > 0) begin
         pop_gap_left--;
         rsp_pop <= 1'b0;
      end else if (verdicts_taken != verdicts_noticed) begin
         verdicts_noticed = verdicts_taken;
         gap = draw_gap(receiver_idles);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            pop_gap_left = gap - 1;
         end else begin
            rsp_pop <= 1'b1;
         end
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin : verdict_check
      verdict_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         verdicts_taken++;
         if (pending_verdicts.size() == 0) begin
            $error("unexpected item: detected %0d colour %0d mean_row_x16 %0d",
                   rsp_detected, rsp_colour, rsp_mean_row_x16);
            mismatch_count++;
         end else begin
            want = pending_verdicts.pop_front();
            check_field("detected", want.detected, rsp_detected);
            check_field("colour", want.colour, rsp_colour);
            check_field("mean_row_x16", want.mean_row_x16, rsp_mean_row_x16);
         end
      end
   end

   // ends the run when no handshake of any kind completes for too long
   always @(posedge clock) begin : watchdog
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      model_cfg.sat_min    = SAT_MIN_RST;
      model_cfg.val_min    = VAL_MIN_RST;
      model_cfg.vote_limit = VOTE_LIMIT_RST;
      model_cfg.row_start  = ROW_START_RST;
      model_cfg.row_end    = ROW_END_RST;
      model_cfg.col_start  = COL_START_RST;
      model_cfg.col_end    = COL_END_RST;
      clear_tallies();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset registers: window rows 96..479, cols 213..425, limit 3
      // two votes then frame end: miss; colour edges and window edges vote nothing
      queue_pixel(255, 128,   0,   96,  213, 1'b0);   // orange, window corner
      queue_pixel(  0,   0, 255,  476,  423, 1'b0);   // blue, far lattice corner
      queue_pixel(  0,   0,   0,  106,  223, 1'b0);   // black
      queue_pixel(255, 255, 255,  106,  233, 1'b0);   // white
      queue_pixel(128, 128, 128,  116,  213, 1'b0);   // grey
      queue_pixel(255,   0,   0,  116,  223, 1'b0);   // hue 0, orange edge
      queue_pixel(255,   0, 255,  116,  233, 1'b0);   // hue 300, pink edge
      queue_pixel(255, 255,   0,  126,  213, 1'b0);   // hue 60, orange edge
      queue_pixel(  0, 255,   0,   97,  213, 1'b0);   // off the lattice
      queue_pixel(  0, 255,   0,  480,  213, 1'b0);   // row bound is exclusive
      queue_pixel(  0, 255,   0,   96,  426, 1'b0);   // column bound is exclusive
      queue_pixel(255, 255, 255, 4095, 4095, 1'b0);   // top coordinates
      queue_pixel(  0, 255,   0,   86,  203, 1'b1);
      // pink and blue tie at two each, lowest index wins; rest of frame ignored
      queue_pixel(255,   0, 200,  136,  213, 1'b0);
      queue_pixel(  0,   0, 255,  146,  213, 1'b0);
      queue_pixel(255,   0, 200,  156,  213, 1'b0);
      queue_pixel(  0,   0, 255,  166,  213, 1'b0);
      queue_pixel(  0, 255,   0,  176,  213, 1'b0);
      queue_pixel(  7, 200,  90,  186,  223, 1'b1);
      // dull and pale pixels sampled without a vote, detection on the last pixel
      queue_pixel(  0, 255,   0,  196,  213, 1'b0);
      queue_pixel(100, 120, 100,  196,  223, 1'b0);
      queue_pixel(200, 210, 200,  196,  233, 1'b0);
      queue_pixel(  0, 200,   0,  206,  213, 1'b0);
      queue_pixel( 20, 255,  20,  206,  223, 1'b0);
      queue_pixel(  0, 255,   0,  206,  233, 1'b1);
      wait_drained();

      // random frames under reset registers
      queue_frames(150, 1, 12, 75);
      wait_drained();

      // zero thresholds and limit, whole frame; no idling on either side
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      set_config(0, 0, 0, 0, 4095, 0, 4095);
      queue_frames(100, 1, 8, 80);
      wait_drained();

      // highest limit, long frames, row sums of up to sixteen votes
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      set_config(200, 500, 15, 0, 4095, 0, 4095);
      queue_frames(200, 20, 45, 90);
      wait_drained();

      // receiver holds off while short frames keep coming, input must stall
      sender_idles = 1'b0;
      set_config(100, 300, 0, 96, 480, 213, 426);
      hold_requests++;
      queue_frames(80, 1, 2, 70);
      wait_drained();
      sender_idles = 1'b1;

      // thresholds above range (upper data bits dropped), inverted and empty window
      set_config(12'hFFF, 1000, 0, 3000, 100, 200, 200);
      queue_frames(30, 1, 6, 90);
      wait_drained();
      set_config(1000, 1023, 2, 0, 4095, 0, 4095);
      queue_frames(30, 1, 6, 90);
      wait_drained();

      // random settings, the first at the top corner of the frame
      for (int pass = 0; pass < 4; pass++) begin
         int rs, cs, re, ce;
         rs = $urandom_range(4000);
         cs = $urandom_range(4000);
         re = rs + $urandom_range(300);
         ce = cs + $urandom_range(300);
         if (re > 4095) re = 4095;
         if (ce > 4095) ce = 4095;
         if (pass == 0)
            set_config(150, 400, 1, 4005, 4095, 4085, 4095);
         else
            set_config(CSR_DATA_W'($urandom_range(600)), CSR_DATA_W'($urandom_range(900)),
                       CSR_DATA_W'($urandom_range(15)), CSR_DATA_W'(rs), CSR_DATA_W'(re),
                       CSR_DATA_W'(cs), CSR_DATA_W'(ce));
         queue_frames(60, 1, 30, 75);
         wait_drained();
      end

      if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
